[hw/rtl/crc32_frame_receiver_macros.svh]
// Assertion macros for the frame receiver
`ifndef CRC32_FRAME_RECEIVER_MACROS_SVH
`define CRC32_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked on clk with reset masked
`define CRCFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk with reset masked
`define CRCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/crcfr_pkg.sv]
`timescale 1ns / 1ps

package crcfr_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// Frame outcome codes
	typedef enum logic [1:0] {
		OUTCOME_OK    = 2'd0,
		OUTCOME_MAGIC = 2'd1,
		OUTCOME_CRC   = 2'd2
	} outcome_t;

	// One result word from the parser core
	typedef struct packed {
		logic        valid;
		logic        has_byte;
		logic [7:0]  payload_byte;
		logic        frame_done;
		outcome_t    outcome;
		logic [7:0]  msg_type;
		logic [7:0]  command_code;
		logic [7:0]  frame_version;
		logic [15:0] status_word;
		logic [31:0] payload_length;
	} result_t;

	// Reflected CRC-32 update over one byte, eight bit steps unrolled
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/crcfr_core.sv]
`timescale 1ns / 1ps

// Header parser, payload counter and CRC check; one byte per step
module crcfr_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data,
	input  logic [15:0]          expected_magic,
	output crcfr_pkg::result_t   res
);

	// Header byte positions
	localparam logic [3:0] POS_MAGIC_END  = 4'd1;
	localparam logic [3:0] POS_VERSION    = 4'd2;
	localparam logic [3:0] POS_TYPE       = 4'd3;
	localparam logic [3:0] POS_COMMAND    = 4'd4;
	localparam logic [3:0] POS_STATUS_END = 4'd6;
	localparam logic [3:0] POS_LENGTH_END = 4'd10;
	localparam logic [3:0] POS_LAST       = 4'd14;

	logic [3:0]  pos_q;
	logic        in_payload_q;
	logic [15:0] magic_q;
	logic [7:0]  version_q;
	logic [7:0]  type_q;
	logic [7:0]  command_q;
	logic [15:0] status_q;
	logic [31:0] length_q;
	logic [31:0] checksum_q;
	logic [31:0] remaining_q;
	logic [31:0] crc_q;

	logic [31:0] crc_next;
	logic [31:0] remaining_next;
	logic        payload_last;
	logic        magic_ok;

	assign crc_next       = crcfr_pkg::crc_byte(crc_q, data);
	assign remaining_next = remaining_q - 32'd1;
	assign payload_last   = (remaining_next == 32'd0);
	assign magic_ok       = (magic_q == expected_magic);

	// Result for the byte at hand
	always_comb begin
		res                = '0;
		res.outcome        = crcfr_pkg::OUTCOME_OK;
		res.msg_type       = type_q;
		res.command_code   = command_q;
		res.frame_version  = version_q;
		res.status_word    = status_q;
		res.payload_length = length_q;
		if (in_payload_q) begin
			res.valid        = 1'b1;
			res.has_byte     = 1'b1;
			res.payload_byte = data;
			if (payload_last) begin
				res.frame_done = 1'b1;
				res.outcome    = (~crc_next == checksum_q) ? crcfr_pkg::OUTCOME_OK
					: crcfr_pkg::OUTCOME_CRC;
			end
		end else if (pos_q == POS_LAST) begin
			if (!magic_ok) begin
				res.valid      = 1'b1;
				res.frame_done = 1'b1;
				res.outcome    = crcfr_pkg::OUTCOME_MAGIC;
			end else if (length_q == 32'd0) begin
				res.valid      = 1'b1;
				res.frame_done = 1'b1;
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			in_payload_q <= 1'b0;
			magic_q      <= '0;
			version_q    <= '0;
			type_q       <= '0;
			command_q    <= '0;
			status_q     <= '0;
			length_q     <= '0;
			checksum_q   <= '0;
			remaining_q  <= '0;
			crc_q        <= crcfr_pkg::CRC_INIT;
		end else if (step) begin
			if (in_payload_q) begin
				crc_q       <= crc_next;
				remaining_q <= remaining_next;
				if (payload_last) begin
					in_payload_q <= 1'b0;
					pos_q        <= '0;
				end
			end else begin
				// capture header fields, big-endian shifts
				if (pos_q <= POS_MAGIC_END) begin
					magic_q <= {magic_q[7:0], data};
				end else if (pos_q == POS_VERSION) begin
					version_q <= data;
				end else if (pos_q == POS_TYPE) begin
					type_q <= data;
				end else if (pos_q == POS_COMMAND) begin
					command_q <= data;
				end else if (pos_q <= POS_STATUS_END) begin
					status_q <= {status_q[7:0], data};
				end else if (pos_q <= POS_LENGTH_END) begin
					length_q <= {length_q[23:0], data};
				end else begin
					checksum_q <= {checksum_q[23:0], data};
				end

				if (pos_q == POS_LAST) begin
					pos_q <= '0;
					if (magic_ok && (length_q != 32'd0)) begin
						in_payload_q <= 1'b1;
						remaining_q  <= length_q;
						crc_q        <= crcfr_pkg::CRC_INIT;
					end
				end else begin
					pos_q <= pos_q + 4'd1;
				end
			end
		end
	end

endmodule

[hw/rtl/crc32_frame_receiver.sv]
// Path: an accepted byte enters the input register, then passes once through the parser
// and the 8-step CRC byte update into the result register. Throughput: one byte per
// cycle while the result register is not held by out_stall.
// Header bytes other than the last produce no result word.
// Reset (arst_n low, asynchronous): parser idle at header byte 0, CRC all ones,
// expected magic 0, both pipeline registers empty.
`timescale 1ns / 1ps

module crc32_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        has_byte,
	output logic [7:0]  payload_byte,
	output logic        frame_done,
	output logic [1:0]  outcome,
	output logic [7:0]  msg_type,
	output logic [7:0]  command_code,
	output logic [7:0]  frame_version,
	output logic [15:0] status_word,
	output logic [31:0] payload_length
);

	`include "crc32_frame_receiver_macros.svh"

	logic [15:0]        expected_magic_q;
	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               out_valid_q;
	crcfr_pkg::result_t out_q;
	crcfr_pkg::result_t res;
	logic               advance;
	logic               step;

	// pipeline moves when the result register is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	// Magic register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_magic_q <= '0;
		end else if (cfg_wr_en) begin
			expected_magic_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
		end
	end

	crcfr_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.data           (data_s1),
		.expected_magic (expected_magic_q),
		.res            (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign has_byte       = out_q.has_byte;
	assign payload_byte   = out_q.payload_byte;
	assign frame_done     = out_q.frame_done;
	assign outcome        = out_q.outcome;
	assign msg_type       = out_q.msg_type;
	assign command_code   = out_q.command_code;
	assign frame_version  = out_q.frame_version;
	assign status_word    = out_q.status_word;
	assign payload_length = out_q.payload_length;

	// Checks
	`CRCFR_ASSERT_NOW(a_stall_has_word, in_stall, valid_s1, "input stalled with empty stage")
	`CRCFR_ASSERT_NEXT(a_held_word_kept, valid_s1 && out_valid_q && out_stall, valid_s1, "input word lost while output held")
	`CRCFR_ASSERT_NOW(a_magic_no_byte, out_valid_q && frame_done && (outcome == crcfr_pkg::OUTCOME_MAGIC), !has_byte, "magic mismatch carries a payload byte")
	`CRCFR_ASSERT_NOW(a_outcome_idle, out_valid_q && !frame_done, outcome == crcfr_pkg::OUTCOME_OK, "outcome set mid-frame")

endmodule

[tb/sv/crc32_frame_receiver_tb.sv]
`timescale 1ns / 1ps

module crc32_frame_receiver_tb;

	localparam int HDR_BYTES       = 15;
	localparam int PIPE_SETTLE     = 4;
	localparam int WATCHDOG_CYCLES = 1000;
	localparam int PHASE_WORDS     = 300;

	// one result word as the parser reports it
	typedef struct packed {
		logic                  has_byte;
		logic [7:0]            payload_byte;
		logic                  frame_done;
		crcfr_pkg::outcome_t   outcome;
		logic [7:0]            msg_type;
		logic [7:0]            command_code;
		logic [7:0]            frame_version;
		logic [15:0]           status_word;
		logic [31:0]           payload_length;
	} rx_result_t;

	// directed frame: header fields, up to two payload bytes, optional magic
	// rewrite after 'cut' header bytes, optional hand-written result
	typedef struct packed {
		logic [15:0] magic;
		logic [7:0]  ver;
		logic [7:0]  typ;
		logic [7:0]  cmd;
		logic [15:0] status;
		logic [31:0] len;
		logic [7:0]  pay0;
		logic [7:0]  pay1;
		bit          crc_calc;
		logic [31:0] crc_x;
		logic [3:0]  cut;
		logic [15:0] cut_magic;
		bit          typed;
		rx_result_t  typed_res;
	} hdr_row_t;

	localparam hdr_row_t DIR_TAB [4] = '{
		// all-ones header against magic 0: mismatch, no payload skipped
		'{magic: 16'hFFFF, ver: 8'hFF, typ: 8'hFF, cmd: 8'hFF, status: 16'hFFFF,
			len: 32'hFFFFFFFF, pay0: 8'h00, pay1: 8'h00, crc_calc: 1'b0,
			crc_x: 32'hFFFFFFFF, cut: 4'd0, cut_magic: 16'h0000, typed: 1'b1,
			typed_res: '{has_byte: 1'b0, payload_byte: 8'h00, frame_done: 1'b1,
				outcome: crcfr_pkg::OUTCOME_MAGIC, msg_type: 8'hFF, command_code: 8'hFF,
				frame_version: 8'hFF, status_word: 16'hFFFF,
				payload_length: 32'hFFFFFFFF}},
		// all-zero header: empty payload, done on the last header byte
		'{magic: 16'h0000, ver: 8'h00, typ: 8'h00, cmd: 8'h00, status: 16'h0000,
			len: 32'h0, pay0: 8'h00, pay1: 8'h00, crc_calc: 1'b0,
			crc_x: 32'h0, cut: 4'd0, cut_magic: 16'h0000, typed: 1'b1,
			typed_res: '{has_byte: 1'b0, payload_byte: 8'h00, frame_done: 1'b1,
				outcome: crcfr_pkg::OUTCOME_OK, msg_type: 8'h00, command_code: 8'h00,
				frame_version: 8'h00, status_word: 16'h0000,
				payload_length: 32'h0}},
		// one-byte payload, good checksum
		'{magic: 16'h0000, ver: 8'h01, typ: 8'h80, cmd: 8'h7F, status: 16'h8001,
			len: 32'd1, pay0: 8'h00, pay1: 8'h00, crc_calc: 1'b1,
			crc_x: 32'h0, cut: 4'd0, cut_magic: 16'h0000, typed: 1'b0,
			typed_res: '0},
		// magic rewritten mid-header; two-byte payload, bad checksum
		'{magic: 16'hFFFF, ver: 8'h5A, typ: 8'hA5, cmd: 8'h3C, status: 16'h00FF,
			len: 32'd2, pay0: 8'hFF, pay1: 8'h00, crc_calc: 1'b1,
			crc_x: 32'h80000000, cut: 4'd5, cut_magic: 16'hFFFF, typed: 1'b0,
			typed_res: '0}
	};

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte   = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic        has_byte;
	logic [7:0]  payload_byte;
	logic        frame_done;
	logic [1:0]  outcome;
	logic [7:0]  msg_type;
	logic [7:0]  command_code;
	logic [7:0]  frame_version;
	logic [15:0] status_word;
	logic [31:0] payload_length;

	crc32_frame_receiver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.has_byte      (has_byte),
		.payload_byte  (payload_byte),
		.frame_done    (frame_done),
		.outcome       (outcome),
		.msg_type      (msg_type),
		.command_code  (command_code),
		.frame_version (frame_version),
		.status_word   (status_word),
		.payload_length(payload_length)
	);

	always #5 clk = ~clk;

	// parser mirror state
	logic [15:0] magic_reg;
	logic [3:0]  hdr_pos;
	bit          in_body;
	logic [15:0] magic_cap;
	logic [7:0]  ver_cap;
	logic [7:0]  type_cap;
	logic [7:0]  cmd_cap;
	logic [15:0] status_cap;
	logic [31:0] len_cap;
	logic [31:0] crc_cap;
	logic [31:0] body_left;
	logic [31:0] crc_acc;

	rx_result_t  pending_results [$];
	logic [7:0]  frame_body [$];
	rx_result_t  exp_word;
	int          err_count    = 0;
	int          burst_left   = 0;
	int          words_sent   = 0;
	int          quiet_cycles = 0;
	logic [15:0] stall_pat    = '0;
	int          stall_left   = 0;
	logic [15:0] phase_magic;

	// reflected CRC-32, one bit at a time, LSB first
	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ b[k];
			c = c >> 1;
			if (fb) begin
				c = c ^ crcfr_pkg::CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] crc32_of_body();
		logic [31:0] c;
		c = crcfr_pkg::CRC_INIT;
		foreach (frame_body[i]) begin
			c = crc_step(c, frame_body[i]);
		end
		return ~c;
	endfunction

	// advance the parser mirror by one byte; returns 1 when a result is due
	function automatic bit parse_word(input logic [7:0] b, output rx_result_t r);
		bit got;
		got = 1'b0;
		r = '0;
		if (in_body) begin
			crc_acc = crc_step(crc_acc, b);
			body_left = body_left - 32'd1;
			got = 1'b1;
			r.has_byte = 1'b1;
			r.payload_byte = b;
			if (body_left == 0) begin
				in_body = 1'b0;
				hdr_pos = '0;
				r.frame_done = 1'b1;
				r.outcome = (~crc_acc == crc_cap) ? crcfr_pkg::OUTCOME_OK
					: crcfr_pkg::OUTCOME_CRC;
			end
		end else begin
			case (hdr_pos)
				0, 1: magic_cap = {magic_cap[7:0], b};
				2: ver_cap = b;
				3: type_cap = b;
				4: cmd_cap = b;
				5, 6: status_cap = {status_cap[7:0], b};
				7, 8, 9, 10: len_cap = {len_cap[23:0], b};
				default: crc_cap = {crc_cap[23:0], b};
			endcase
			if (hdr_pos != HDR_BYTES - 1) begin
				hdr_pos = hdr_pos + 4'd1;
			end else begin
				hdr_pos = '0;
				if (magic_cap != magic_reg) begin
					got = 1'b1;
					r.frame_done = 1'b1;
					r.outcome = crcfr_pkg::OUTCOME_MAGIC;
				end else if (len_cap == 0) begin
					got = 1'b1;
					r.frame_done = 1'b1;
					r.outcome = crcfr_pkg::OUTCOME_OK;
				end else begin
					in_body = 1'b1;
					body_left = len_cap;
					crc_acc = crcfr_pkg::CRC_INIT;
				end
			end
		end
		r.msg_type = type_cap;
		r.command_code = cmd_cap;
		r.frame_version = ver_cap;
		r.status_word = status_cap;
		r.payload_length = len_cap;
		return got;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
		end
	endtask

	// send one byte word; bursts with random gaps in between
	task automatic send_word(input logic [7:0] b, input bit typed, input rx_result_t typed_res);
		rx_result_t r;
		bit got;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 20);
		end
		burst_left--;
		data_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		got = parse_word(b, r);
		if (got || typed) begin
			pending_results.push_back(typed ? typed_res : r);
		end
		words_sent++;
	endtask

	// wait for the pipeline to empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_magic(input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		magic_reg = v;
	endtask

	// header bytes MSB first, then frame_body
	task automatic send_frame(input logic [119:0] hdr, input logic [3:0] cut,
			input logic [15:0] cut_magic, input bit typed, input rx_result_t typed_res);
		for (int i = 0; i < HDR_BYTES; i++) begin
			if (cut != 0 && i == cut) begin
				drain();
				write_magic(cut_magic);
			end
			send_word(hdr[119 - 8 * i -: 8], typed && (i == HDR_BYTES - 1), typed_res);
		end
		foreach (frame_body[i]) begin
			send_word(frame_body[i], 1'b0, '0);
		end
	endtask

	// mostly good frames with random content; some bad magic, bad CRC, noise
	task automatic random_frame();
		int kind;
		int n;
		logic [31:0] len;
		logic [31:0] crc;
		logic [15:0] magic;
		logic [7:0]  v;
		logic [7:0]  t;
		logic [7:0]  c;
		logic [15:0] s;
		kind = $urandom_range(0, 99);
		v = 8'($urandom_range(0, 255));
		t = 8'($urandom_range(0, 255));
		c = 8'($urandom_range(0, 255));
		s = 16'($urandom_range(0, 65535));
		frame_body.delete();
		if (kind < 72) begin
			n = $urandom_range(0, 19);
			len = (n == 0) ? 32'd0 : (n < 16) ? $urandom_range(1, 8) : $urandom_range(9, 48);
			repeat (len) frame_body.push_back(8'($urandom_range(0, 255)));
			crc = crc32_of_body();
			n = $urandom_range(0, 7);
			if (n == 0) begin
				crc = crc ^ (32'd1 << $urandom_range(0, 31));
			end else if (n == 1) begin
				crc = $urandom;
			end
			send_frame({magic_reg, v, t, c, s, len, crc}, '0, '0, 1'b0, '0);
		end else if (kind < 88) begin
			magic = magic_reg ^ 16'($urandom_range(1, 65535));
			len = $urandom;
			crc = $urandom;
			send_frame({magic, v, t, c, s, len, crc}, '0, '0, 1'b0, '0);
		end else begin
			// partial header that can never match, then filler to realign
			send_word(~magic_reg[15:8], 1'b0, '0);
			repeat ($urandom_range(0, 13)) send_word(8'($urandom_range(0, 255)), 1'b0, '0);
			while (in_body || hdr_pos != 0) begin
				send_word(8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result word, byte %0h", payload_byte));
			end else begin
				exp_word = pending_results.pop_front();
				check_field("has_byte", 32'(has_byte), 32'(exp_word.has_byte));
				check_field("payload_byte", 32'(payload_byte), 32'(exp_word.payload_byte));
				check_field("frame_done", 32'(frame_done), 32'(exp_word.frame_done));
				check_field("outcome", 32'(outcome), 32'(exp_word.outcome));
				check_field("msg_type", 32'(msg_type), 32'(exp_word.msg_type));
				check_field("command_code", 32'(command_code), 32'(exp_word.command_code));
				check_field("frame_version", 32'(frame_version),
					32'(exp_word.frame_version));
				check_field("status_word", 32'(status_word), 32'(exp_word.status_word));
				check_field("payload_length", payload_length, exp_word.payload_length);
			end
		end
	end

	// receiver stall pattern, swapped out every so often
	always @(posedge clk) begin
		if (stall_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat <= '0;
				1: stall_pat <= 16'($urandom);
				2: stall_pat <= 16'($urandom & $urandom);
				default: stall_pat <= 16'hFF00;
			endcase
			stall_left <= $urandom_range(16, 200);
			out_stall <= 1'b0;
		end else begin
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
			stall_left <= stall_left - 1;
			out_stall <= stall_pat[0];
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		magic_reg = '0;
		hdr_pos = '0;
		in_body = 1'b0;
		magic_cap = '0;
		ver_cap = '0;
		type_cap = '0;
		cmd_cap = '0;
		status_cap = '0;
		len_cap = '0;
		crc_cap = '0;
		body_left = '0;
		crc_acc = crcfr_pkg::CRC_INIT;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, starting against the reset magic
		foreach (DIR_TAB[i]) begin
			frame_body.delete();
			if (DIR_TAB[i].len != 0 && DIR_TAB[i].len <= 2) begin
				frame_body.push_back(DIR_TAB[i].pay0);
				if (DIR_TAB[i].len == 2) begin
					frame_body.push_back(DIR_TAB[i].pay1);
				end
			end
			send_frame({DIR_TAB[i].magic, DIR_TAB[i].ver, DIR_TAB[i].typ, DIR_TAB[i].cmd,
				DIR_TAB[i].status, DIR_TAB[i].len,
				DIR_TAB[i].crc_calc ? (crc32_of_body() ^ DIR_TAB[i].crc_x) : DIR_TAB[i].crc_x},
				DIR_TAB[i].cut, DIR_TAB[i].cut_magic, DIR_TAB[i].typed, DIR_TAB[i].typed_res);
		end

		// random phases, magic changed between them
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: phase_magic = 16'hFFFF;
				2: phase_magic = 16'h0000;
				4: phase_magic = 16'h8001;
				default: phase_magic = 16'($urandom_range(0, 65535));
			endcase
			drain();
			write_magic(phase_magic);
			words_sent = 0;
			while (words_sent < PHASE_WORDS) begin
				random_frame();
			end
		end

		drain();
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_core.sv
hw/rtl/crc32_frame_receiver.sv
tb/sv/crc32_frame_receiver_tb.sv
